// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, sampled on clk_i and disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle (consequent may be a sequence)
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/avrt_pkg.sv
// ----------------------------------------------------------------------------
// avrt_pkg
// shared types, codes and index helpers for the axis rotation pipeline
// ----------------------------------------------------------------------------
package avrt_pkg;

  // width of the cosine and sine registers as written over the bus
  localparam int COEF_WIDTH = 18;

  // register indexes (address bit 2)
  localparam logic REG_COS = 1'b0;
  localparam logic REG_SIN = 1'b1;

  // axis codes; the unused code behaves as the x axis
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [1:0] {
    CMD_VECTOR = 2'd0,
    CMD_TENSOR = 2'd1,
    CMD_VOIGT  = 2'd2
  } cmd_e;

  // (a + sh) mod 3 for a, sh in 0..2
  function automatic logic [1:0] rot3(input logic [1:0] a, input logic [1:0] sh);
    logic [2:0] s;
    s = {1'b0, a} + {1'b0, sh};
    if (s >= 3'd3) begin
      s = s - 3'd3;
    end
    return s[1:0];
  endfunction

  // canonical index a -> original index, canonical order is (i, j, k)
  function automatic logic [1:0] perm_idx(input logic [1:0] axis, input logic [1:0] a);
    logic [1:0] sh;
    case (axis)
      AXIS_Y:  sh = 2'd2;
      AXIS_Z:  sh = 2'd0;
      default: sh = 2'd1;
    endcase
    return rot3(a, sh);
  endfunction

  // original index r -> canonical index
  function automatic logic [1:0] inv_idx(input logic [1:0] axis, input logic [1:0] r);
    logic [1:0] sh;
    case (axis)
      AXIS_Y:  sh = 2'd1;
      AXIS_Z:  sh = 2'd0;
      default: sh = 2'd2;
    endcase
    return rot3(r, sh);
  endfunction

endpackage

// File: hw/rtl/avrt_rot_pass.sv
// ----------------------------------------------------------------------------
// avrt_rot_pass
// two-stage rotation of three component pairs: products, then sum and saturate
// ----------------------------------------------------------------------------
module avrt_rot_pass #(
  parameter int CW  = 32,
  parameter int FB  = 16,
  parameter int KIN = 18
) (
  input  logic                  clk_i,
  input  logic signed [KIN-1:0] cos_i,
  input  logic signed [KIN-1:0] sin_i,
  input  logic signed [CW-1:0]  a_i [3],
  input  logic signed [CW-1:0]  b_i [3],
  output logic signed [CW-1:0]  a_o [3],
  output logic signed [CW-1:0]  b_o [3]
);

  localparam int KW = KIN + 1;
  localparam int PW = CW + KW;
  localparam int TW = PW - FB;
  localparam int SW = (TW + 1 > CW + 1) ? TW + 1 : CW + 1;
  localparam logic signed [SW-1:0] MAXV = (SW'(1) <<< (CW - 1)) - SW'(1);
  localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

  logic signed [KW-1:0] kc, ks, kn;
  logic signed [PW-1:0] p_ac [3], p_bs [3], p_an [3], p_bc [3];
  logic signed [TW-1:0] ac_q [3], bs_q [3], an_q [3], bc_q [3];
  logic signed [SW-1:0] sum_a [3], sum_b [3];

  assign kc = KW'(cos_i);
  assign ks = KW'(sin_i);
  assign kn = -ks;

  function automatic logic signed [CW-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    r = v;
    if (v > MAXV) begin
      r = MAXV;
    end else if (v < MINV) begin
      r = MINV;
    end
    return r[CW-1:0];
  endfunction

  // exact products, floor by dropping the fraction bits
  always_comb begin
    for (int n = 0; n < 3; n++) begin
      p_ac[n] = a_i[n] * kc;
      p_bs[n] = b_i[n] * ks;
      p_an[n] = a_i[n] * kn;
      p_bc[n] = b_i[n] * kc;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int n = 0; n < 3; n++) begin
      ac_q[n] <= p_ac[n][PW-1:FB];
      bs_q[n] <= p_bs[n][PW-1:FB];
      an_q[n] <= p_an[n][PW-1:FB];
      bc_q[n] <= p_bc[n][PW-1:FB];
    end
  end

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      sum_a[n] = SW'(ac_q[n]) + SW'(bs_q[n]);
      sum_b[n] = SW'(an_q[n]) + SW'(bc_q[n]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int n = 0; n < 3; n++) begin
      a_o[n] <= sat(sum_a[n]);
      b_o[n] <= sat(sum_b[n]);
    end
  end

endmodule

// File: hw/rtl/axis_rotate_vector_tensor.sv
// ----------------------------------------------------------------------------
// axis_rotate_vector_tensor
// a transaction runs through the load, row, column and output stages to done_o
// throughput: one transaction per cycle, busy is held low
// reset (async, active low): pipeline emptied, cos = 1.0, sin = 0
// the result is shown for one cycle; the receiver cannot stall it
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module axis_rotate_vector_tensor import avrt_pkg::*; #(
  parameter int COMP_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // command side
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   cmd_i,
  input  logic [1:0]                   axis_i,
  input  logic signed [COMP_WIDTH-1:0] comp0_i,
  input  logic signed [COMP_WIDTH-1:0] comp1_i,
  input  logic signed [COMP_WIDTH-1:0] comp2_i,
  input  logic signed [COMP_WIDTH-1:0] comp3_i,
  input  logic signed [COMP_WIDTH-1:0] comp4_i,
  input  logic signed [COMP_WIDTH-1:0] comp5_i,
  input  logic signed [COMP_WIDTH-1:0] comp6_i,
  input  logic signed [COMP_WIDTH-1:0] comp7_i,
  input  logic signed [COMP_WIDTH-1:0] comp8_i,
  input  logic                         last_row_i,
  // result side
  output logic                         done_o,
  output logic signed [COMP_WIDTH-1:0] res0_o,
  output logic signed [COMP_WIDTH-1:0] res1_o,
  output logic signed [COMP_WIDTH-1:0] res2_o,
  output logic signed [COMP_WIDTH-1:0] res3_o,
  output logic signed [COMP_WIDTH-1:0] res4_o,
  output logic signed [COMP_WIDTH-1:0] res5_o,
  output logic signed [COMP_WIDTH-1:0] res6_o,
  output logic signed [COMP_WIDTH-1:0] res7_o,
  output logic signed [COMP_WIDTH-1:0] res8_o,
  output logic                         last_out_o
);

  localparam int CW = COMP_WIDTH;
  // coefficient storage wide enough to hold 1.0 at any fraction width
  localparam int CKW = (FRAC_BITS + 2 > COEF_WIDTH) ? FRAC_BITS + 2 : COEF_WIDTH;
  localparam logic signed [CKW-1:0] COS_RESET = CKW'(1) << FRAC_BITS;
  localparam int NST = 6;

  typedef struct packed {
    cmd_e       cmd;
    logic [1:0] axis;
    logic       last;
  } ctrl_t;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic signed [CKW-1:0] cos_q, sin_q;
  logic                  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q <= COS_RESET;
      sin_q <= '0;
    end else if (cfg_wr) begin
      // writes sign-extend the 18-bit Q2.16 value
      if (paddr[2] == REG_COS) begin
        cos_q <= CKW'(signed'(pwdata[COEF_WIDTH-1:0]));
      end else begin
        sin_q <= CKW'(signed'(pwdata[COEF_WIDTH-1:0]));
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_COS) begin
      prdata = 32'(cos_q);
    end else begin
      prdata = 32'(sin_q);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: load into canonical order (i, j, k) so the rotated pair is
  // always rows/columns 0 and 1
  // ---------------------------------------------------------------------------
  logic                  accept;
  logic signed [CW-1:0]  x [9];
  logic signed [CW-1:0]  t_in [3][3];
  logic signed [CW-1:0]  p_in [3][3];
  cmd_e                  cmd_in;
  logic                  vld_q [NST];
  ctrl_t                 ctl_q [NST];
  logic signed [CW-1:0]  m1_q [3][3];

  // the pipeline never stalls, so start is accepted every cycle it is high
  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign cmd_in = cmd_e'(cmd_i);

  assign x[0] = comp0_i;
  assign x[1] = comp1_i;
  assign x[2] = comp2_i;
  assign x[3] = comp3_i;
  assign x[4] = comp4_i;
  assign x[5] = comp5_i;
  assign x[6] = comp6_i;
  assign x[7] = comp7_i;
  assign x[8] = comp8_i;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        t_in[r][c] = '0;
        p_in[r][c] = '0;
      end
    end
    case (cmd_in)
      CMD_TENSOR: begin
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            t_in[r][c] = x[3*r+c];
          end
        end
      end
      CMD_VOIGT: begin
        // xx yy zz yz xz xy expanded to a symmetric matrix
        t_in[0][0] = x[0]; t_in[0][1] = x[5]; t_in[0][2] = x[4];
        t_in[1][0] = x[5]; t_in[1][1] = x[1]; t_in[1][2] = x[3];
        t_in[2][0] = x[4]; t_in[2][1] = x[3]; t_in[2][2] = x[2];
      end
      default: begin
      end
    endcase
    if (cmd_in == CMD_VECTOR) begin
      // the vector rides in canonical column 0, the rest stays zero
      for (int a = 0; a < 3; a++) begin
        p_in[a][0] = x[4'(perm_idx(axis_i, 2'(a)))];
      end
    end else begin
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          p_in[a][b] = t_in[perm_idx(axis_i, 2'(a))][perm_idx(axis_i, 2'(b))];
        end
      end
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NST; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else begin
      vld_q[0] <= accept;
      for (int s = 1; s < NST; s++) begin
        vld_q[s] <= vld_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_q[0] <= '{cmd: cmd_in, axis: axis_i, last: last_row_i};
    for (int s = 1; s < NST; s++) begin
      ctl_q[s] <= ctl_q[s-1];
    end
    m1_q <= p_in;
  end

  // ---------------------------------------------------------------------------
  // stages 2-3: row pass on canonical rows 0 and 1, row 2 is delayed alongside
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] row_a_in [3], row_b_in [3];
  logic signed [CW-1:0] row_a [3], row_b [3];
  logic signed [CW-1:0] r2_q [3], r3_q [3];
  logic signed [CW-1:0] m3 [3][3];

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      row_a_in[n] = m1_q[0][n];
      row_b_in[n] = m1_q[1][n];
    end
  end

  avrt_rot_pass #(
    .CW  (CW),
    .FB  (FRAC_BITS),
    .KIN (CKW)
  ) u_row_pass (
    .clk_i (clk_i),
    .cos_i (cos_q),
    .sin_i (sin_q),
    .a_i   (row_a_in),
    .b_i   (row_b_in),
    .a_o   (row_a),
    .b_o   (row_b)
  );

  always_ff @(posedge clk_i) begin
    for (int n = 0; n < 3; n++) begin
      r2_q[n] <= m1_q[2][n];
      r3_q[n] <= r2_q[n];
    end
  end

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      m3[0][n] = row_a[n];
      m3[1][n] = row_b[n];
      m3[2][n] = r3_q[n];
    end
  end

  // ---------------------------------------------------------------------------
  // stages 4-5: column pass on canonical columns 0 and 1; column 2 and the
  // row-pass column 0 (the vector result) are delayed alongside
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] col_a_in [3], col_b_in [3];
  logic signed [CW-1:0] col_a [3], col_b [3];
  logic signed [CW-1:0] c4_q [3], c5_q [3];
  logic signed [CW-1:0] vec4_q [3], vec5_q [3];
  logic signed [CW-1:0] m5 [3][3];

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      col_a_in[n] = m3[n][0];
      col_b_in[n] = m3[n][1];
    end
  end

  avrt_rot_pass #(
    .CW  (CW),
    .FB  (FRAC_BITS),
    .KIN (CKW)
  ) u_col_pass (
    .clk_i (clk_i),
    .cos_i (cos_q),
    .sin_i (sin_q),
    .a_i   (col_a_in),
    .b_i   (col_b_in),
    .a_o   (col_a),
    .b_o   (col_b)
  );

  always_ff @(posedge clk_i) begin
    for (int n = 0; n < 3; n++) begin
      c4_q[n]   <= m3[n][2];
      c5_q[n]   <= c4_q[n];
      vec4_q[n] <= m3[n][0];
      vec5_q[n] <= vec4_q[n];
    end
  end

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      m5[n][0] = col_a[n];
      m5[n][1] = col_b[n];
      m5[n][2] = c5_q[n];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: back to the original order, pack per command, zero unused lanes
  // ---------------------------------------------------------------------------
  ctrl_t                ctl5;
  logic signed [CW-1:0] u [3][3];
  logic signed [CW-1:0] res_d [9];
  logic signed [CW-1:0] res_q [9];
  logic                 last_q;

  assign ctl5 = ctl_q[NST-2];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        u[r][c] = m5[inv_idx(ctl5.axis, 2'(r))][inv_idx(ctl5.axis, 2'(c))];
      end
    end
    for (int n = 0; n < 9; n++) begin
      res_d[n] = '0;
    end
    case (ctl5.cmd)
      CMD_VECTOR: begin
        for (int r = 0; r < 3; r++) begin
          res_d[r] = vec5_q[inv_idx(ctl5.axis, 2'(r))];
        end
      end
      CMD_TENSOR: begin
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            res_d[3*r+c] = u[r][c];
          end
        end
      end
      CMD_VOIGT: begin
        res_d[0] = u[0][0];
        res_d[1] = u[1][1];
        res_d[2] = u[2][2];
        res_d[3] = u[1][2];
        res_d[4] = u[0][2];
        res_d[5] = u[0][1];
      end
      default: begin
        // reserved command: all lanes stay zero
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    last_q <= ctl5.last;
  end

  assign done_o     = vld_q[NST-1];
  assign res0_o     = res_q[0];
  assign res1_o     = res_q[1];
  assign res2_o     = res_q[2];
  assign res3_o     = res_q[3];
  assign res4_o     = res_q[4];
  assign res5_o     = res_q[5];
  assign res6_o     = res_q[6];
  assign res7_o     = res_q[7];
  assign res8_o     = res_q[8];
  assign last_out_o = last_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `ASSERT_IMPLY(a_latency, start && !busy, ##6 done_o, "accepted transaction lost in pipeline")
  `ASSERT_IMPLY(a_no_spurious, done_o, $past(start, 6), "result without an accepted transaction")
  `ASSERT_IMPLY(a_vec_zero_lanes, done_o && ctl_q[NST-1].cmd == CMD_VECTOR,
    res3_o == '0 && res4_o == '0 && res5_o == '0 && res6_o == '0 && res7_o == '0 && res8_o == '0,
    "vector result with nonzero upper lanes")

endmodule

// File: tb/axis_rotate_vector_tensor_test.sv
// ----------------------------------------------------------------------------
// axis_rotate_vector_tensor_test
// self-checking bench for the axis rotation pipeline: rows of vectors, full
// tensors, voigt tensors and reserved commands are streamed in bursts under
// several angle settings, and every result is compared lane by lane against a
// bit-exact fixed point predictor held in a small scoreboard
// ----------------------------------------------------------------------------
module axis_rotate_vector_tensor_test;
  timeunit 1ns;
  timeprecision 1ps;

  import avrt_pkg::*;

  localparam int COMP_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int LATENCY     = 6;
  localparam int STALL_LIMIT = 500;
  localparam int MAX_SHOWN   = 10;
  localparam int PHASES      = 12;
  localparam int PHASE_ROWS  = 128;

  // codes with no name in the package
  localparam logic [1:0] CMD_NONE  = 2'd3;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  localparam logic [31:0] COMP_MAX = 32'h7fff_ffff;
  localparam logic [31:0] COMP_MIN = 32'h8000_0000;

  // nine lanes of one row, lane 0 in the low bits
  typedef logic [8:0][COMP_W-1:0] lanes_t;

  typedef struct packed {
    lanes_t lane;
    logic   last;
  } rot_row_t;

  // --------------------------------------------------------------------------
  // scoreboard: fixed point rotation predictor plus the queue of rows in flight
  // --------------------------------------------------------------------------
  class rotation_board;
    longint   cos_q = 65536;
    longint   sin_q = 0;
    longint   work[9];
    rot_row_t awaited_rows[$];
    int       mismatches = 0;

    // register write: only the low coefficient bits count, sign extended
    function void set_coef(logic reg_sel, logic [31:0] value);
      longint v;
      v = longint'($signed(value[COEF_WIDTH-1:0]));
      if (reg_sel == REG_COS) begin
        cos_q = v;
      end else begin
        sin_q = v;
      end
    endfunction

    // exact product, then floor by the fraction bits
    function longint scale(longint x, longint c);
      return (x * c) >>> FRAC_W;
    endfunction

    function longint clamp(longint v);
      longint top;
      top = (longint'(1) <<< (COMP_W - 1)) - 1;
      if (v > top) return top;
      if (v < -top - 1) return -top - 1;
      return v;
    endfunction

    // rotate one (i, j) pair of the working row in place
    function void turn(int p, int q);
      longint xi, xj;
      xi = work[p];
      xj = work[q];
      work[p] = clamp(scale(xi, cos_q) + scale(xj, sin_q));
      work[q] = clamp(scale(xi, -sin_q) + scale(xj, cos_q));
    endfunction

    // q t q^t: rows first, saturated, then columns
    function void turn_tensor(int i, int j);
      for (int n = 0; n < 3; n++) turn(i * 3 + n, j * 3 + n);
      for (int n = 0; n < 3; n++) turn(n * 3 + i, n * 3 + j);
    endfunction

    function rot_row_t rotate_row(logic [1:0] cmd, logic [1:0] axis, lanes_t comp,
                                  logic last);
      rot_row_t r;
      longint   x[9];
      longint   packed_back[9];
      int       i, j, k;
      // the unused axis code behaves as the x axis
      k = (axis == AXIS_NONE) ? 0 : int'(axis);
      i = (k + 1) % 3;
      j = (k + 2) % 3;
      for (int n = 0; n < 9; n++) begin
        x[n]    = longint'($signed(comp[n]));
        work[n] = 0;
      end
      case (cmd)
        CMD_VECTOR: begin
          for (int n = 0; n < 3; n++) work[n] = x[n];
          turn(i, j);
        end
        CMD_TENSOR: begin
          work = x;
          turn_tensor(i, j);
        end
        CMD_VOIGT: begin
          // voigt order xx yy zz yz xz xy expanded to a symmetric 3x3
          work[0] = x[0]; work[1] = x[5]; work[2] = x[4];
          work[3] = x[5]; work[4] = x[1]; work[5] = x[3];
          work[6] = x[4]; work[7] = x[3]; work[8] = x[2];
          turn_tensor(i, j);
          packed_back[0] = work[0]; packed_back[1] = work[4];
          packed_back[2] = work[8]; packed_back[3] = work[5];
          packed_back[4] = work[2]; packed_back[5] = work[1];
          packed_back[6] = 0; packed_back[7] = 0; packed_back[8] = 0;
          work = packed_back;
        end
        default: begin
          // unknown command gives an all-zero row
        end
      endcase
      for (int n = 0; n < 9; n++) r.lane[n] = work[n][COMP_W-1:0];
      r.last = last;
      return r;
    endfunction

    function void note_row(logic [1:0] cmd, logic [1:0] axis, lanes_t comp, logic last);
      awaited_rows.insert(awaited_rows.size(), rotate_row(cmd, axis, comp, last));
    endfunction

    function void check_row(rot_row_t seen);
      rot_row_t want;
      if (awaited_rows.size() == 0) begin
        if (mismatches < MAX_SHOWN) begin
          $display("%0t: result with no transaction outstanding: lanes %h last %b",
                   $realtime, seen.lane, seen.last);
        end
        mismatches++;
        return;
      end
      want = awaited_rows.pop_front();
      if (want != seen) begin
        if (mismatches < MAX_SHOWN) begin
          $display("%0t: mismatch\n  expected lanes %h last %b\n  actual   lanes %h last %b",
                   $realtime, want.lane, want.last, seen.lane, seen.last);
        end
        mismatches++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // signals, all inputs known from time zero
  // --------------------------------------------------------------------------
  logic                     clk_i      = 1'b0;
  logic                     rst_ni     = 1'b0;
  logic                     psel       = 1'b0;
  logic                     penable    = 1'b0;
  logic                     pwrite     = 1'b0;
  logic [2:0]               paddr      = '0;
  logic [31:0]              pwdata     = '0;
  logic [31:0]              prdata;
  logic                     pready;
  logic                     start      = 1'b0;
  logic                     busy;
  logic [1:0]               cmd_i      = '0;
  logic [1:0]               axis_i     = '0;
  logic signed [COMP_W-1:0] comp0_i    = '0;
  logic signed [COMP_W-1:0] comp1_i    = '0;
  logic signed [COMP_W-1:0] comp2_i    = '0;
  logic signed [COMP_W-1:0] comp3_i    = '0;
  logic signed [COMP_W-1:0] comp4_i    = '0;
  logic signed [COMP_W-1:0] comp5_i    = '0;
  logic signed [COMP_W-1:0] comp6_i    = '0;
  logic signed [COMP_W-1:0] comp7_i    = '0;
  logic signed [COMP_W-1:0] comp8_i    = '0;
  logic                     last_row_i = 1'b0;
  logic                     done_o;
  logic signed [COMP_W-1:0] res0_o, res1_o, res2_o, res3_o, res4_o;
  logic signed [COMP_W-1:0] res5_o, res6_o, res7_o, res8_o;
  logic                     last_out_o;

  rotation_board board = new();
  int            stall_cycles = 0;

  axis_rotate_vector_tensor #(
    .COMP_WIDTH(COMP_W),
    .FRAC_BITS (FRAC_W)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .start     (start),
    .busy      (busy),
    .cmd_i     (cmd_i),
    .axis_i    (axis_i),
    .comp0_i   (comp0_i),
    .comp1_i   (comp1_i),
    .comp2_i   (comp2_i),
    .comp3_i   (comp3_i),
    .comp4_i   (comp4_i),
    .comp5_i   (comp5_i),
    .comp6_i   (comp6_i),
    .comp7_i   (comp7_i),
    .comp8_i   (comp8_i),
    .last_row_i(last_row_i),
    .done_o    (done_o),
    .res0_o    (res0_o),
    .res1_o    (res1_o),
    .res2_o    (res2_o),
    .res3_o    (res3_o),
    .res4_o    (res4_o),
    .res5_o    (res5_o),
    .res6_o    (res6_o),
    .res7_o    (res7_o),
    .res8_o    (res8_o),
    .last_out_o(last_out_o)
  );

  // 100 MHz clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // result monitor: a strobed result is taken at the edge that ends its cycle
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      board.check_row(rot_row_t'({res8_o, res7_o, res6_o, res5_o, res4_o,
                                  res3_o, res2_o, res1_o, res0_o, last_out_o}));
    end
  end

  // watchdog: too many cycles with neither a transaction nor a result
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("** axis_rotate_vector_tensor: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // component values weighted toward the saturation and rounding corners
  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 7))
      0:       return COMP_MAX;
      1:       return COMP_MIN;
      2:       return $urandom_range(0, 1) ? 32'h0 : 32'hffff_ffff;
      3, 4:    return 32'($signed($urandom_range(0, 262143)) - 131072);
      default: return $urandom;
    endcase
  endfunction

  function automatic lanes_t rand_lanes();
    lanes_t l;
    for (int n = 0; n < 9; n++) l[n] = rand_comp();
    return l;
  endfunction

  // present one row and hold it until the block takes it
  task automatic send_row(logic [1:0] cmd, logic [1:0] axis, lanes_t comp, logic last);
    start      <= 1'b1;
    cmd_i      <= cmd;
    axis_i     <= axis;
    comp0_i    <= comp[0];
    comp1_i    <= comp[1];
    comp2_i    <= comp[2];
    comp3_i    <= comp[3];
    comp4_i    <= comp[4];
    comp5_i    <= comp[5];
    comp6_i    <= comp[6];
    comp7_i    <= comp[7];
    comp8_i    <= comp[8];
    last_row_i <= last;
    do @(posedge clk_i); while (busy);
    board.note_row(cmd, axis, comp, last);
  endtask

  // sender gap: start is held low for the given number of clock edges
  task automatic pause(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // stop sending and wait for every outstanding row to come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (board.awaited_rows.size() != 0);
  endtask

  // write cosine then sine back to back; psel stays up between the two
  task automatic set_angle(logic [31:0] cos_val, logic [31:0] sin_val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_COS, 2'b00};
    pwdata  <= cos_val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.set_coef(REG_COS, cos_val);
    penable <= 1'b0;
    paddr   <= {REG_SIN, 2'b00};
    pwdata  <= sin_val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.set_coef(REG_SIN, sin_val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // random rows in bursts of random length with random gaps
  task automatic stream_rows(int rows);
    int         burst;
    logic [1:0] cmd;
    burst = $urandom_range(1, 40);
    repeat (rows) begin
      cmd = ($urandom_range(0, 19) == 0) ? CMD_NONE : 2'($urandom_range(0, 2));
      send_row(cmd, 2'($urandom_range(0, 3)), rand_lanes(), $urandom_range(0, 7) == 0);
      burst--;
      if (burst == 0) begin
        if ($urandom_range(0, 3) != 0) begin
          pause($urandom_range(1, 8));
        end
        burst = $urandom_range(1, 40);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  int cos_set[8] = '{65536, 0, -65536, 0, 46341, -131072, 131071, 39322};
  int sin_set[8] = '{0, 65536, 0, -65536, 46341, 131071, -131072, -52429};

  initial begin
    lanes_t alt;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset angle is zero: identity rotation on each named command, zero row otherwise
    send_row(CMD_VECTOR, AXIS_X, rand_lanes(), 1'b0);
    send_row(CMD_TENSOR, AXIS_Y, rand_lanes(), 1'b1);
    send_row(CMD_VOIGT, AXIS_Z, rand_lanes(), 1'b0);
    send_row(CMD_NONE, AXIS_NONE, rand_lanes(), 1'b1);
    drain();

    // directed: every named command on every axis code, then the corners
    set_angle(32'd39322, 32'd52429);
    for (int c = 0; c < 3; c++) begin
      for (int a = 0; a < 4; a++) begin
        send_row(2'(c), 2'(a), rand_lanes(), a == 3);
      end
    end
    send_row(CMD_TENSOR, AXIS_X, {9{COMP_MAX}}, 1'b0);
    send_row(CMD_TENSOR, AXIS_Z, {9{COMP_MIN}}, 1'b1);
    for (int n = 0; n < 9; n++) alt[n] = n[0] ? COMP_MIN : COMP_MAX;
    send_row(CMD_VOIGT, AXIS_Y, alt, 1'b0);
    send_row(CMD_VECTOR, AXIS_Y, '0, 1'b0);
    // all ones: floor of small negatives
    send_row(CMD_VECTOR, AXIS_Z, '1, 1'b1);
    send_row(CMD_NONE, AXIS_Y, {9{COMP_MAX}}, 1'b0);
    drain();

    // random phases: fixed angles first (quadrants, 45 degrees, out of range
    // coefficients), then random register values with junk in the upper bits
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 8) begin
        set_angle(32'(cos_set[ph]), 32'(sin_set[ph]));
      end else begin
        set_angle($urandom, $urandom);
      end
      stream_rows(PHASE_ROWS);
      drain();
    end

    // let any stray result show up
    repeat (LATENCY + 4) @(posedge clk_i);
    if (board.mismatches == 0 && board.awaited_rows.size() == 0) begin
      $display("** axis_rotate_vector_tensor: PASSED **");
    end else begin
      $display("** axis_rotate_vector_tensor: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/avrt_pkg.sv
hw/rtl/avrt_rot_pass.sv
hw/rtl/axis_rotate_vector_tensor.sv
tb/axis_rotate_vector_tensor_test.sv
